[hw/rtl/avs_pkg.sv]
// ----------------------------------------------------------------------------
// avs_pkg: shared types and constants for the media presentation clock
// Holds field widths, event and decision codes, register indexes and the
// command bundle that drives the serial arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package avs_pkg;

  // Time and count widths.
  localparam int TIME_BITS  = 40;
  localparam int COUNT_BITS = 32;
  localparam int RUN_W      = TIME_BITS - 1;      // unsigned tick count range
  localparam int DIFF_W     = TIME_BITS + 1;      // signed difference of two times
  localparam int MAG_W      = DIFF_W;             // magnitude of a difference
  localparam int FRAC_BITS  = 8;                  // Q3.8 speed fraction
  localparam int QUO_W      = MAG_W + FRAC_BITS;  // scaled dividend and quotient
  localparam int SPEED_W    = 11;
  localparam int PROD_W     = RUN_W + SPEED_W;
  localparam int WIN_W      = 16;
  localparam int SRC_W      = 2;
  localparam int ACT_W      = 3;
  localparam int DEC_W      = 2;
  localparam int DELAY_W    = 40;
  localparam int IDX_W      = 2;
  localparam int CNT_W      = $clog2(QUO_W);

  // Event codes.
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESUME = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_AUDIO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_VIDEO  = 3'd6;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd7;

  // Frame decisions.
  localparam logic [DEC_W-1:0] DEC_DISPLAY = 2'd0;
  localparam logic [DEC_W-1:0] DEC_WAIT    = 2'd1;
  localparam logic [DEC_W-1:0] DEC_SKIP    = 2'd2;

  // Master clock sources; any other code selects the tick clock.
  localparam logic [SRC_W-1:0] SRC_AUDIO = 2'd0;
  localparam logic [SRC_W-1:0] SRC_VIDEO = 2'd1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MASTER = 2'd0;
  localparam logic [IDX_W-1:0] REG_SPEED  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SYNC   = 2'd2;
  localparam logic [IDX_W-1:0] REG_SKIP   = 2'd3;

  // Register reset values and speed limits.
  localparam logic [SRC_W-1:0]   MASTER_RST = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_RST  = 11'd256;
  localparam logic [SPEED_W-1:0] SPEED_MIN  = 11'd64;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 11'd1024;
  localparam logic [WIN_W-1:0]   SYNC_RST   = 16'd40;
  localparam logic [WIN_W-1:0]   SKIP_RST   = 16'd500;

  // Commands to the serial unit.
  typedef struct packed {
    logic load_mul;
    logic step_mul;
    logic load_div;
    logic step_div;
  } avs_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/avs_serial_unit.sv]
// ----------------------------------------------------------------------------
// avs_serial_unit: bit-serial multiply and divide by the playback speed
// One shift register and one narrow partial register serve both a
// shift-add multiply (one multiplier bit per cycle) and a restoring divide
// (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module avs_serial_unit
  import avs_pkg::*;
(
  input  logic                clk,
  input  avs_cmd_t            cmd,
  input  logic [SPEED_W-1:0]  speed,
  input  logic [RUN_W-1:0]    mul_src,
  input  logic [MAG_W-1:0]    div_src,
  output logic [PROD_W-1:0]   product,
  output logic [QUO_W-1:0]    quotient
);

  logic [QUO_W-1:0]   work;
  logic [SPEED_W-1:0] part;

  logic [SPEED_W:0]   mul_sum;
  logic [SPEED_W:0]   div_shift;
  logic               div_fit;
  logic [SPEED_W:0]   div_diff;

  // Multiply step: add the speed when the next multiplier bit is set.
  assign mul_sum = {1'b0, part} + (work[0] ? {1'b0, speed} : '0);

  // Divide step: bring in the next dividend bit and try the subtraction.
  assign div_shift = {part, work[QUO_W-1]};
  assign div_fit   = div_shift >= {1'b0, speed};
  assign div_diff  = div_shift - {1'b0, speed};

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      work <= {{(QUO_W-RUN_W){1'b0}}, mul_src};
      part <= '0;
    end else if (cmd.step_mul) begin
      work <= {mul_sum[0], work[QUO_W-1:1]};
      part <= mul_sum[SPEED_W:1];
    end else if (cmd.load_div) begin
      work <= {div_src, {FRAC_BITS{1'b0}}};
      part <= '0;
    end else if (cmd.step_div) begin
      work <= {work[QUO_W-2:0], div_fit};
      part <= div_fit ? div_diff[SPEED_W-1:0] : div_shift[SPEED_W-1:0];
    end
  end

  // After the multiply the low product bits sit at the top of the shift register.
  assign product  = {part, work[QUO_W-1 -: RUN_W]};
  assign quotient = work;

endmodule

`default_nettype wire

[hw/rtl/av_sync_decision_clock_top.sv]
// Sequence: an accepted event passes S_POS and then S_DONE; on the tick clock it
// also passes S_MUL for the bit-serial position multiply and S_PSAT, and a
// frame query also passes S_DIFF and S_DIV for the bit-serial divide by speed.
// One event at a time: a new event is taken only in S_IDLE, after the last
// result has left S_DONE, where a stalled output holds it.
// Synchronous reset (rst) sets register defaults, clock and sequencer state.
// ----------------------------------------------------------------------------
// av_sync_decision_clock_top: media presentation clock with frame sync
// Keeps the tick count, pause flag, last audio and video times and the
// dropped-frame count, and answers display, wait or skip for frame queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module av_sync_decision_clock_top
  import avs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Configuration writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [WIN_W-1:0]          cfg_data,
  // Event requests.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ACT_W-1:0]          action,
  input  logic signed [TIME_BITS-1:0] timestamp_ms,
  // Results.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DEC_W-1:0]          decision,
  output logic [DELAY_W-1:0]        delay_ms,
  output logic signed [TIME_BITS-1:0] position_ms,
  output logic signed [DIFF_W-1:0]  av_difference_ms,
  output logic [COUNT_BITS-1:0]     frames_dropped
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POS  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PSAT = 3'd3;
  localparam logic [2:0] S_DIFF = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration registers.
  logic [SRC_W-1:0]   master_source;
  logic [SPEED_W-1:0] speed_q8;
  logic [WIN_W-1:0]   sync_window_ms;
  logic [WIN_W-1:0]   skip_window_ms;

  // Clock state.
  logic [RUN_W-1:0]          running_ms;
  logic                      paused;
  logic [TIME_BITS-1:0]      audio_time;
  logic [TIME_BITS-1:0]      video_time;
  logic [COUNT_BITS-1:0]     drop_count;

  // Sequencer and working registers.
  logic [2:0]                state;
  logic [CNT_W-1:0]          step_cnt;
  logic [ACT_W-1:0]          act;
  logic [TIME_BITS-1:0]      ts;
  logic [TIME_BITS-1:0]      pos;
  logic                      neg;

  avs_cmd_t                  cmd;
  logic [PROD_W-1:0]         product;
  logic [QUO_W-1:0]          quotient;

  logic                      ext_clock;
  logic                      is_query;
  logic [DIFF_W-1:0]         diff_fwd;
  logic [DIFF_W-1:0]         diff_rev;
  logic [MAG_W-1:0]          magnitude;
  logic [TIME_BITS-1:0]      pos_sat;
  logic                      wait_hit;
  logic                      skip_hit;
  logic [QUO_W-1:0]          delay_full;
  logic [DELAY_W-1:0]        delay_sat;
  logic [DIFF_W-1:0]         av_diff;
  logic [SPEED_W-1:0]        speed_wr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign ext_clock = (master_source != SRC_AUDIO) && (master_source != SRC_VIDEO);
  assign is_query  = (act == ACT_QUERY);
  assign speed_wr  = cfg_data[SPEED_W-1:0];

  // Commands to the serial unit.
  always_comb begin
    cmd.load_mul = (state == S_POS) && ext_clock;
    cmd.step_mul = (state == S_MUL);
    cmd.load_div = (state == S_DIFF);
    cmd.step_div = (state == S_DIV);
  end

  avs_serial_unit u_serial (
    .clk      (clk),
    .cmd      (cmd),
    .speed    (speed_q8),
    .mul_src  (running_ms),
    .div_src  (magnitude),
    .product  (product),
    .quotient (quotient)
  );

  // Tick clock position: product divided by 256, saturated to the time maximum.
  assign pos_sat = (|product[PROD_W-1:RUN_W+FRAC_BITS]) ? {1'b0, {RUN_W{1'b1}}}
                 : {1'b0, product[RUN_W+FRAC_BITS-1:FRAC_BITS]};

  // Frame lead over the master clock, split into sign and magnitude.
  assign diff_fwd  = {ts[TIME_BITS-1], ts} - {pos[TIME_BITS-1], pos};
  assign diff_rev  = {pos[TIME_BITS-1], pos} - {ts[TIME_BITS-1], ts};
  assign magnitude = diff_fwd[DIFF_W-1] ? diff_rev : diff_fwd;

  // Decision on the scaled lead.
  assign wait_hit   = is_query && !neg && (quotient > QUO_W'(sync_window_ms));
  assign skip_hit   = is_query && neg && (quotient > QUO_W'(skip_window_ms));
  assign delay_full = quotient - QUO_W'(sync_window_ms);
  assign delay_sat  = (|delay_full[QUO_W-1:DELAY_W]) ? {DELAY_W{1'b1}}
                    : delay_full[DELAY_W-1:0];

  // Video time minus audio time always fits the wider signed range.
  assign av_diff = {video_time[TIME_BITS-1], video_time}
                 - {audio_time[TIME_BITS-1], audio_time};

  // Configuration writes; an out-of-range speed is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_source  <= MASTER_RST;
      speed_q8       <= SPEED_RST;
      sync_window_ms <= SYNC_RST;
      skip_window_ms <= SKIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MASTER: master_source <= cfg_data[SRC_W-1:0];
        REG_SPEED: begin
          if (speed_wr >= SPEED_MIN && speed_wr <= SPEED_MAX) begin
            speed_q8 <= speed_wr;
          end
        end
        REG_SYNC: sync_window_ms <= cfg_data;
        REG_SKIP: skip_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event sequencer and clock state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      running_ms <= '0;
      paused     <= 1'b0;
      audio_time <= '0;
      video_time <= '0;
      drop_count <= '0;
      step_cnt   <= '0;
    end else begin
      // A result loaded in S_DONE takes over the output register instead.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act   <= action;
            ts    <= timestamp_ms;
            state <= S_POS;
            case (action)
              ACT_TICK: begin
                if (!paused && running_ms != {RUN_W{1'b1}}) begin
                  running_ms <= running_ms + 1'b1;
                end
              end
              ACT_START: begin
                running_ms <= '0;
                paused     <= 1'b0;
                audio_time <= '0;
                video_time <= '0;
                drop_count <= '0;
              end
              ACT_PAUSE:  paused <= 1'b1;
              ACT_RESUME: paused <= 1'b0;
              ACT_RESET: begin
                running_ms <= '0;
                audio_time <= '0;
                video_time <= '0;
              end
              ACT_AUDIO: audio_time <= timestamp_ms;
              ACT_VIDEO: video_time <= timestamp_ms;
              default: ;
            endcase
          end
        end
        // Pick the master clock, or start the position multiply.
        S_POS: begin
          step_cnt <= '0;
          if (ext_clock) begin
            state <= S_MUL;
          end else begin
            pos   <= (master_source == SRC_AUDIO) ? audio_time : video_time;
            state <= is_query ? S_DIFF : S_DONE;
          end
        end
        S_MUL: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == CNT_W'(RUN_W - 1)) begin
            state <= S_PSAT;
          end
        end
        S_PSAT: begin
          pos   <= pos_sat;
          state <= is_query ? S_DIFF : S_DONE;
        end
        S_DIFF: begin
          neg      <= diff_fwd[DIFF_W-1];
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == CNT_W'(QUO_W - 1)) begin
            state <= S_DONE;
          end
        end
        // Load the result once the output register is free.
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            position_ms      <= pos;
            av_difference_ms <= av_diff;
            if (wait_hit) begin
              decision <= DEC_WAIT;
              delay_ms <= delay_sat;
            end else if (skip_hit) begin
              decision <= DEC_SKIP;
              delay_ms <= '0;
            end else begin
              decision <= DEC_DISPLAY;
              delay_ms <= '0;
            end
            if (skip_hit && drop_count != {COUNT_BITS{1'b1}}) begin
              drop_count     <= drop_count + 1'b1;
              frames_dropped <= drop_count + 1'b1;
            end else begin
              frames_dropped <= drop_count;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
